FILE: src/bsst_pkg.sv
package bsst_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int SAMPLE_W = 32;
  localparam int CAP_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int SPAN_W   = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_NEW  = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         add_status;
    logic [COUNT_W-1:0] distinct_count;
    logic               span_valid;
    logic [SPAN_W-1:0]  shortest_span;
    logic [SPAN_W-1:0]  longest_span;
  } result_t;

endpackage

FILE: src/bsst_if.sv
interface bsst_sample_if import bsst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface bsst_result_if import bsst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         add_status;
  logic [COUNT_W-1:0] distinct_count;
  logic               span_valid;
  logic [SPAN_W-1:0]  shortest_span;
  logic [SPAN_W-1:0]  longest_span;

  modport source (output valid, output add_status, output distinct_count,
                  output span_valid, output shortest_span, output longest_span,
                  input ready);
  modport sink (input valid, input add_status, input distinct_count,
                input span_valid, input shortest_span, input longest_span,
                output ready);
endinterface

FILE: src/bounded_set_span_tracker.sv
// each accepted sample beat passes through SCAN, COMMIT and EMIT before its result beat;
//   when the capacity is used up it goes from IDLE straight to EMIT
// a new sample is taken only once the last one has left EMIT; the scan reads every held
//   value through the store port
// the result register lets the next sample be taken while a result waits
// reset: store empty, all slots free, capacity 64; store contents need no clearing
module bounded_set_span_tracker import bsst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  bsst_sample_if.sink      sample_i,
  bsst_result_if.source    result_o
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [CAP_W-1:0]      capacity_q;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  result_t               out_q;
  logic                  out_vld_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  bsst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsst_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .in_value_i  (sample_i.sample_value),
    .capacity_i  (capacity_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // output register, refilled as soon as the waiting beat leaves
  assign res_ready = !out_vld_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.add_status     = out_q.add_status;
  assign result_o.distinct_count = out_q.distinct_count;
  assign result_o.span_valid     = out_q.span_valid;
  assign result_o.shortest_span  = out_q.shortest_span;
  assign result_o.longest_span   = out_q.longest_span;

endmodule

FILE: src/bsst_ram.sv
module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bsst_ctrl.sv
module bsst_ctrl import bsst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   in_value_i,
  input  logic [CAP_W-1:0]      capacity_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [VALUE_BITS-1:0] ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [VALUE_BITS-1:0] ram_rdata_i
);

  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] SIGN_FLIP = {1'b1, {(VB-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [VB-1:0]    val_q, val_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [VB-1:0]    diff_q, diff_d;
  logic             diff_vld_q, diff_vld_d;
  logic             dup_q, dup_d;
  logic [VB:0]      cand_q, cand_d;
  status_e          status_q, status_d;
  logic [CAP_W-1:0] slots_q, slots_d;
  logic [CW-1:0]    held_q, held_d;
  logic [VB-1:0]    small_q, small_d;
  logic [VB-1:0]    large_q, large_d;
  logic [VB:0]      gap_q, gap_d;

  logic             scan_done;
  logic [VB-1:0]    span_full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign ram_re_o    = (state_q == S_SCAN) && (rd_idx_q < held_q);
  assign ram_raddr_o = rd_idx_q[AW-1:0];
  assign ram_waddr_o = held_q[AW-1:0];
  assign ram_wdata_o = val_q;
  assign scan_done   = (rd_idx_q == held_q) && !rd_vld_q && !diff_vld_q;
  assign span_full   = large_q - small_q;

  always_comb begin
    res_o.add_status     = status_q;
    res_o.distinct_count = COUNT_W'(held_q);
    res_o.span_valid     = (held_q >= CW'(2));
    if (held_q >= CW'(2)) begin
      res_o.shortest_span = SPAN_W'(gap_q);
      res_o.longest_span  = SPAN_W'(span_full);
    end else begin
      res_o.shortest_span = '0;
      res_o.longest_span  = '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    val_d      = val_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    diff_d     = diff_q;
    diff_vld_d = 1'b0;
    dup_d      = dup_q;
    cand_d     = cand_q;
    status_d   = status_q;
    slots_d    = slots_q;
    held_d     = held_q;
    small_d    = small_q;
    large_d    = large_q;
    gap_d      = gap_q;
    ram_we_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // sign bit flipped so unsigned order follows signed order
          val_d    = VB'($unsigned(in_value_i)) ^ SIGN_FLIP;
          rd_idx_d = '0;
          dup_d    = 1'b0;
          cand_d   = '1;
          if (slots_q >= capacity_i) begin
            status_d = ST_FULL;
            state_d  = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ram_re_o) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        rd_vld_d = ram_re_o;
        // stage 1: compare and absolute difference
        if (rd_vld_q) begin
          if (ram_rdata_i == val_q) begin
            dup_d = 1'b1;
          end
          if (ram_rdata_i > val_q) begin
            diff_d = ram_rdata_i - val_q;
          end else begin
            diff_d = val_q - ram_rdata_i;
          end
        end
        diff_vld_d = rd_vld_q;
        // stage 2: running minimum gap against the new value
        if (diff_vld_q && ({1'b0, diff_q} < cand_q)) begin
          cand_d = {1'b0, diff_q};
        end
        if (scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (dup_q) begin
          status_d = ST_DUP;
          slots_d  = slots_q + CAP_W'(1);
        end else if (held_q == CW'(MAX_ENTRIES)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_NEW;
          ram_we_o = 1'b1;
          if (cand_q < gap_q) begin
            gap_d = cand_q;
          end
          if (held_q == '0) begin
            small_d = val_q;
            large_d = val_q;
          end else begin
            if (val_q < small_q) begin
              small_d = val_q;
            end
            if (val_q > large_q) begin
              large_d = val_q;
            end
          end
          held_d  = held_q + CW'(1);
          slots_d = slots_q + CAP_W'(1);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
      slots_q    <= '0;
      held_q     <= '0;
      small_q    <= '0;
      large_q    <= '0;
      gap_q      <= '1;
      status_q   <= ST_NEW;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      diff_vld_q <= diff_vld_d;
      slots_q    <= slots_d;
      held_q     <= held_d;
      small_q    <= small_d;
      large_q    <= large_d;
      gap_q      <= gap_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    rd_idx_q <= rd_idx_d;
    diff_q   <= diff_d;
    dup_q    <= dup_d;
    cand_q   <= cand_d;
  end

endmodule
